// ===== sv/text_console_cell_writer_defines.svh =====
// Assertion macros for the text console cell writer.
// Used by the top level; expects clk and rst_n in scope.
`ifndef TEXT_CONSOLE_CELL_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_CELL_WRITER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TCW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/tcw_pkg.sv =====
// Shared types, constants and codes for the text console cell writer.
// No dependencies; imported by every module of the block.
`default_nettype none

package tcw_pkg;

  localparam int MAX_COLS = 128;
  localparam int MAX_ROWS = 64;
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int ADDR_W   = COL_W + ROW_W;
  localparam int DEPTH    = MAX_COLS * MAX_ROWS;
  localparam int TAB_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;

  localparam logic [2:0] KIND_PRINT  = 3'd0;
  localparam logic [2:0] KIND_GOTO   = 3'd1;
  localparam logic [2:0] KIND_CLEAR  = 3'd2;
  localparam logic [2:0] KIND_FILL   = 3'd3;
  localparam logic [2:0] KIND_TRANSP = 3'd4;
  localparam logic [2:0] KIND_STORE  = 3'd5;
  localparam logic [2:0] KIND_READ   = 3'd6;

  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_TAB     = 8'd9;

  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAB     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN  = 2'd3;

  typedef struct packed {
    logic       transp;
    logic       blink;
    logic [3:0] bg;
    logic [3:0] fg;
    logic [7:0] ch;
  } cell_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [7:0]       ch;
    logic [3:0]       fg;
    logic [3:0]       bg;
    logic             blink;
    logic             transp;
    logic [COL_W-1:0] tcol;
    logic [ROW_W-1:0] trow;
  } item_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    cell_t            cell_val;
  } res_t;

  typedef struct packed {
    logic [COL_W-1:0] last_col;
    logic [ROW_W-1:0] last_row;
    logic [COL_W-1:0] margin;
    logic [TAB_W-1:0] tab_stop;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    cell_t             wdata;
  } ram_req_t;

  typedef struct packed {
    logic             start;
    logic [TAB_W-1:0] dividend;
    logic [TAB_W-1:0] divisor;
  } rem_req_t;

  typedef struct packed {
    logic             done;
    logic [TAB_W-1:0] rem;
  } rem_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WIPE,
    ST_EXEC,
    ST_PRT_WR,
    ST_FILL_RD,
    ST_FILL_WR,
    ST_TAB_M1,
    ST_TAB_M2,
    ST_TAB_STEP,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== sv/text_console_cell_writer.sv =====
// Text console cell writer: configuration registers, store, sequencer.
// Depends on tcw_pkg, tcw_cell_ram, tcw_rem_unit, tcw_ctrl and the defines header.
//
// Usage:
//   Input channel in_*: one operation per beat (print, goto, clear, fill
//   background, all transparent, store cell, read cell). in_ready is high
//   only while the sequencer is idle; one beat is worked on at a time.
//   Output channel out_*: one result beat per input beat, held in an output
//   register until taken. While it waits, the next input beat may be taken,
//   but its result is held back until the register frees.
//   Config channel cfg_*: always ready; index 0 columns, 1 rows, 2 tab stop,
//   3 left margin. Write only while no operation is in flight.
// Steps from accept to result valid: goto, newline, store, read, unused
//   kind: execute, done; printable byte: execute (cell read), cell write,
//   done; tab: col and margin remainders by the tab stop through the shared
//   remainder unit, then advances tried, one per cycle, through the cursor
//   adder; fill, all transparent: a read and a write per cell over all
//   columns*rows cells; clear: 8192 writes. in_ready rises with out_valid.
// Reset: synchronous, active low; then a clearing pass zeroes all 8192 store
//   cells, with in_ready low; config writes are taken throughout.
`default_nettype none
`include "text_console_cell_writer_defines.svh"

module text_console_cell_writer (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [tcw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [tcw_pkg::CFG_DAT_W-1:0]    cfg_data,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  [2:0]                       in_kind,
  input  wire  [7:0]                       in_character,
  input  wire  [3:0]                       in_fg_color,
  input  wire  [3:0]                       in_bg_color,
  input  wire                              in_blink_on,
  input  wire                              in_transparent_on,
  input  wire  [tcw_pkg::COL_W-1:0]        in_target_col,
  input  wire  [tcw_pkg::ROW_W-1:0]        in_target_row,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [tcw_pkg::COL_W-1:0]        out_cursor_col,
  output logic [tcw_pkg::ROW_W-1:0]        out_cursor_row,
  output logic [7:0]                       out_cell_character,
  output logic [3:0]                       out_cell_fg,
  output logic [3:0]                       out_cell_bg,
  output logic                             out_cell_blink,
  output logic                             out_cell_transparent
);
  import tcw_pkg::*;

  logic [7:0] columns_r, columns_nxt;
  logic [6:0] rows_r, rows_nxt;
  logic [7:0] tab_r, tab_nxt;
  logic [6:0] margin_r, margin_nxt;

  cfg_t     cfg;
  item_t    in_item;
  res_t     res;
  ram_req_t ram_req;
  cell_t    ram_rdata;
  rem_req_t rem_req;
  rem_rsp_t rem_rsp;

  assign cfg_ready = 1'b1;

  always_comb begin
    columns_nxt = columns_r;
    rows_nxt    = rows_r;
    tab_nxt     = tab_r;
    margin_nxt  = margin_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_COLUMNS: columns_nxt = cfg_data;
        CFG_ROWS:    rows_nxt    = cfg_data[6:0];
        CFG_TAB:     tab_nxt     = cfg_data;
        CFG_MARGIN:  margin_nxt  = cfg_data[6:0];
        default:     columns_nxt = columns_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r <= 8'd80;
      rows_r    <= 7'd25;
      tab_r     <= 8'd4;
      margin_r  <= 7'd0;
    end else begin
      columns_r <= columns_nxt;
      rows_r    <= rows_nxt;
      tab_r     <= tab_nxt;
      margin_r  <= margin_nxt;
    end
  end

  always_comb begin
    if (columns_r == '0) begin
      cfg.last_col = '0;
    end else if (columns_r > 8'(MAX_COLS)) begin
      cfg.last_col = COL_W'(MAX_COLS - 1);
    end else begin
      cfg.last_col = COL_W'(columns_r - 8'd1);
    end
    if (rows_r == '0) begin
      cfg.last_row = '0;
    end else if (rows_r > 7'(MAX_ROWS)) begin
      cfg.last_row = ROW_W'(MAX_ROWS - 1);
    end else begin
      cfg.last_row = ROW_W'(rows_r - 7'd1);
    end
    cfg.margin   = (COL_W'(margin_r) <= cfg.last_col) ? COL_W'(margin_r) : cfg.last_col;
    cfg.tab_stop = (tab_r == '0) ? TAB_W'(1) : tab_r;
  end

  assign in_item = '{kind: in_kind, ch: in_character, fg: in_fg_color, bg: in_bg_color,
                     blink: in_blink_on, transp: in_transparent_on,
                     tcol: in_target_col, trow: in_target_row};

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .rem_req   (rem_req),
    .rem_rsp   (rem_rsp)
  );

  tcw_cell_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  tcw_rem_unit u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rem_req),
    .rsp   (rem_rsp)
  );

  assign out_cursor_col       = res.col;
  assign out_cursor_row       = res.row;
  assign out_cell_character   = res.cell_val.ch;
  assign out_cell_fg          = res.cell_val.fg;
  assign out_cell_bg          = res.cell_val.bg;
  assign out_cell_blink       = res.cell_val.blink;
  assign out_cell_transparent = res.cell_val.transp;

  `TCW_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "beat taken while busy")
  `TCW_ASSERT_NOW(a_cursor_on_screen, out_valid,
    out_cursor_col <= cfg.last_col && out_cursor_row <= cfg.last_row, "cursor off screen")
  `TCW_ASSERT_NOW(a_store_idle_when_ready, in_ready, !ram_req.we && !ram_req.re,
    "store access while idle")

endmodule

`default_nettype wire

// ===== sv/tcw_cell_ram.sv =====
// Character cell store: one port; a write, a registered read or both per cycle.
// Depends on tcw_pkg.
`default_nettype none

module tcw_cell_ram (
  input  wire              clk,
  input  tcw_pkg::ram_req_t req,
  output tcw_pkg::cell_t    rdata
);
  import tcw_pkg::*;

  cell_t mem [DEPTH];
  cell_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== sv/tcw_rem_unit.sv =====
// Iterative remainder unit: one compare and subtract per cycle.
// Depends on tcw_pkg.
`default_nettype none

module tcw_rem_unit (
  input  wire               clk,
  input  wire               rst_n,
  input  tcw_pkg::rem_req_t req,
  output tcw_pkg::rem_rsp_t rsp
);
  import tcw_pkg::*;

  logic             busy_r, busy_nxt;
  logic [TAB_W-1:0] work_r, work_nxt;
  logic [TAB_W-1:0] div_r, div_nxt;
  logic             fin;

  assign fin      = busy_r && (work_r < div_r);
  assign rsp.done = fin;
  assign rsp.rem  = work_r;

  always_comb begin
    busy_nxt = busy_r;
    work_nxt = work_r;
    div_nxt  = div_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      work_nxt = req.dividend;
      div_nxt  = req.divisor;
    end else if (busy_r) begin
      if (fin) begin
        busy_nxt = 1'b0;
      end else begin
        work_nxt = work_r - div_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    work_r <= work_nxt;
    div_r  <= div_nxt;
  end

endmodule

`default_nettype wire

// ===== sv/tcw_ctrl.sv =====
// Sequencer: cursor, store sweeps, tab stepping and the result register.
// Depends on tcw_pkg; drives tcw_cell_ram and tcw_rem_unit.
`default_nettype none

module tcw_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  tcw_pkg::cfg_t     cfg,
  input  wire               in_valid,
  output logic              in_ready,
  input  tcw_pkg::item_t    in_item,
  output logic              out_valid,
  input  wire               out_ready,
  output tcw_pkg::res_t     out_res,
  output tcw_pkg::ram_req_t ram_req,
  input  tcw_pkg::cell_t    ram_rdata,
  output tcw_pkg::rem_req_t rem_req,
  input  tcw_pkg::rem_rsp_t rem_rsp
);
  import tcw_pkg::*;

  state_t            state_r, state_nxt;
  item_t             item_r, item_nxt;
  logic              from_item_r, from_item_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [ADDR_W-1:0] wipe_r, wipe_nxt;
  logic [COL_W-1:0]  fc_r, fc_nxt;
  logic [ROW_W-1:0]  fr_r, fr_nxt;
  logic [TAB_W-1:0]  rem_r, rem_nxt;
  logic [TAB_W-1:0]  mrem_r, mrem_nxt;
  logic              out_valid_r, out_valid_nxt;
  res_t              res_r, res_nxt;

  logic              at_last_col, can_nl, adv_stuck, adv_jump;
  logic [COL_W-1:0]  adv_col;
  logic [ROW_W-1:0]  adv_row;
  logic [TAB_W-1:0]  rem_inc, rem_step;
  cell_t             cell_w;

  assign at_last_col = (col_r == cfg.last_col);
  assign can_nl      = (row_r < cfg.last_row);
  assign adv_stuck   = at_last_col && !can_nl;
  assign adv_jump    = at_last_col && can_nl;
  assign adv_col     = at_last_col ? (can_nl ? cfg.margin : col_r) : col_r + 1'b1;
  assign adv_row     = adv_jump ? row_r + 1'b1 : row_r;
  assign rem_inc     = rem_r + 1'b1;
  assign rem_step    = (rem_inc == cfg.tab_stop) ? '0 : rem_inc;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    from_item_nxt = from_item_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    wipe_nxt      = wipe_r;
    fc_nxt        = fc_r;
    fr_nxt        = fr_r;
    rem_nxt       = rem_r;
    mrem_nxt      = mrem_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ram_req       = '0;
    rem_req       = '0;
    cell_w        = ram_rdata;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt      = in_item;
          from_item_nxt = 1'b1;
          col_nxt       = (col_r > cfg.last_col) ? cfg.last_col : col_r;
          row_nxt       = (row_r > cfg.last_row) ? cfg.last_row : row_r;
          state_nxt     = ST_EXEC;
        end
      end
      ST_WIPE: begin
        ram_req.we    = 1'b1;
        ram_req.addr  = wipe_r;
        ram_req.wdata = '0;
        wipe_nxt      = wipe_r + 1'b1;
        if (wipe_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = from_item_r ? ST_DONE : ST_IDLE;
        end
      end
      ST_EXEC: begin
        case (item_r.kind)
          KIND_PRINT: begin
            if (item_r.ch == CH_NEWLINE) begin
              if (can_nl) begin
                col_nxt = cfg.margin;
                row_nxt = row_r + 1'b1;
              end
              state_nxt = ST_DONE;
            end else if (item_r.ch == CH_TAB) begin
              rem_req.start    = 1'b1;
              rem_req.dividend = TAB_W'(col_r);
              rem_req.divisor  = cfg.tab_stop;
              state_nxt        = ST_TAB_M1;
            end else begin
              ram_req.re   = 1'b1;
              ram_req.addr = {row_r, col_r};
              state_nxt    = ST_PRT_WR;
            end
          end
          KIND_GOTO: begin
            if (item_r.tcol <= cfg.last_col && item_r.trow <= cfg.last_row) begin
              col_nxt = item_r.tcol;
              row_nxt = item_r.trow;
            end
            state_nxt = ST_DONE;
          end
          KIND_CLEAR: begin
            col_nxt   = '0;
            row_nxt   = '0;
            wipe_nxt  = '0;
            state_nxt = ST_WIPE;
          end
          KIND_FILL, KIND_TRANSP: begin
            fc_nxt    = '0;
            fr_nxt    = '0;
            state_nxt = ST_FILL_RD;
          end
          KIND_STORE: begin
            ram_req.we    = 1'b1;
            ram_req.addr  = {row_r, col_r};
            ram_req.wdata = '{transp: item_r.transp, blink: item_r.blink,
                              bg: item_r.bg, fg: item_r.fg, ch: item_r.ch};
            state_nxt     = ST_DONE;
          end
          KIND_READ: begin
            ram_req.re   = 1'b1;
            ram_req.addr = {row_r, col_r};
            state_nxt    = ST_DONE;
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_PRT_WR: begin
        cell_w.ch     = item_r.ch;
        cell_w.fg     = item_r.fg;
        cell_w.bg     = item_r.bg;
        cell_w.blink  = item_r.blink;
        ram_req.we    = 1'b1;
        ram_req.addr  = {row_r, col_r};
        ram_req.wdata = cell_w;
        col_nxt       = adv_col;
        row_nxt       = adv_row;
        state_nxt     = ST_DONE;
      end
      ST_FILL_RD: begin
        ram_req.re   = 1'b1;
        ram_req.addr = {fr_r, fc_r};
        state_nxt    = ST_FILL_WR;
      end
      ST_FILL_WR: begin
        if (item_r.kind == KIND_FILL) begin
          cell_w.bg = item_r.bg;
        end else begin
          cell_w.transp = 1'b1;
        end
        ram_req.we    = 1'b1;
        ram_req.addr  = {fr_r, fc_r};
        ram_req.wdata = cell_w;
        state_nxt     = ST_FILL_RD;
        if (fc_r == cfg.last_col) begin
          fc_nxt = '0;
          if (fr_r == cfg.last_row) begin
            state_nxt = ST_DONE;
          end else begin
            fr_nxt = fr_r + 1'b1;
          end
        end else begin
          fc_nxt = fc_r + 1'b1;
        end
      end
      ST_TAB_M1: begin
        if (rem_rsp.done) begin
          rem_nxt          = rem_rsp.rem;
          rem_req.start    = 1'b1;
          rem_req.dividend = TAB_W'(cfg.margin);
          rem_req.divisor  = cfg.tab_stop;
          state_nxt        = ST_TAB_M2;
        end
      end
      ST_TAB_M2: begin
        if (rem_rsp.done) begin
          mrem_nxt  = rem_rsp.rem;
          state_nxt = ST_TAB_STEP;
        end
      end
      ST_TAB_STEP: begin
        if (adv_stuck) begin
          state_nxt = ST_DONE;
        end else begin
          col_nxt = adv_col;
          row_nxt = adv_row;
          if (adv_jump) begin
            rem_nxt = mrem_r;
            if (mrem_r == '0) begin
              state_nxt = ST_DONE;
            end
          end else begin
            rem_nxt = rem_step;
            if (rem_step == '0) begin
              state_nxt = ST_DONE;
            end
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt    = 1'b1;
          res_nxt.col      = col_r;
          res_nxt.row      = row_r;
          res_nxt.cell_val = (item_r.kind == KIND_READ) ? ram_rdata : '0;
          from_item_nxt    = 1'b0;
          state_nxt        = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_WIPE;
      from_item_r <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
      wipe_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      from_item_r <= from_item_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      wipe_r      <= wipe_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r <= item_nxt;
    fc_r   <= fc_nxt;
    fr_r   <= fr_nxt;
    rem_r  <= rem_nxt;
    mrem_r <= mrem_nxt;
    res_r  <= res_nxt;
  end

endmodule

`default_nettype wire
